/* hdl/crc16_frame_checker_macros.svh */
// Assertion macros shared by the frame checker RTL.
`ifndef CRC16_FRAME_CHECKER_MACROS_SVH
`define CRC16_FRAME_CHECKER_MACROS_SVH

// Antecedent holds, consequent holds in the same cycle.
`define CRC16FC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds, consequent holds in the following cycle.
`define CRC16FC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/crc16fc_pkg.sv */
// Types, constants and the CRC byte update for the frame checker.
package crc16fc_pkg;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_SHORT  = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_LEN_MISM   = 3'd3,
        ST_CRC_MISM   = 3'd4
    } status_t;

    localparam logic [7:0]  HDR_BYTE0   = 8'h5A;
    localparam logic [7:0]  HDR_BYTE1   = 8'hA5;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [7:0]  CMD_KEY_RPT = 8'h83;
    localparam int          MIN_FRAME   = 6;
    localparam int          LEN_OFFSET  = 3;

    // Register index of crc_enable
    localparam logic REG_CRC_ENABLE = 1'b0;

    // One byte through the reflected CRC-16, eight shifts unrolled
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* hdl/crc16_frame_checker.sv */
// Frame checker top level: byte counting, CRC-16, field capture and verdict.
//
//  Channel | Ports                                  | Direction | Moves
//  --------+----------------------------------------+-----------+---------------------
//  input   | s_valid/s_ready, s_rx_byte, s_frame_end | in        | one byte per request
//  result  | m_valid/m_ready, m_status ... m_*_crc   | out       | one verdict per frame
//  config  | psel/penable/pwrite/paddr/pwdata/prdata | in/out    | crc_enable at 0x0
//
//  A byte is taken each cycle while s_ready is high; CRC update unrolled over 8 bits.
//  The verdict appears on the result registers the cycle after the last byte.
//  s_ready drops only while a verdict waits and m_ready is low.
//  Reset (aresetn low, synchronous) clears the frame state and m_valid and sets crc_enable.
`include "crc16_frame_checker_macros.svh"

module crc16_frame_checker #(
    parameter int MAX_FRAME = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // byte input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,
    input  logic                              s_frame_end,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_status,
    output logic [$clog2(MAX_FRAME + 2)-1:0]  m_frame_length,
    output logic [7:0]                        m_command,
    output logic [15:0]                       m_vp_address,
    output logic [7:0]                        m_key_action,
    output logic [7:0]                        m_key_id,
    output logic                              m_is_key_report,
    output logic [15:0]                       m_received_crc,
    output logic [15:0]                       m_computed_crc,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import crc16fc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 2);
    localparam int LW = ((CW > 9) ? CW : 9) + 1;
    localparam logic [CW-1:0] CNT_SAT = CW'(MAX_FRAME + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME);

    // Frame state
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic          header_good_reg, header_good_next;
    logic [7:0]    length_byte_reg, length_byte_next;
    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    dly0_reg, dly0_next;
    logic [7:0]    dly1_reg, dly1_next;
    logic [7:0]    command_reg, command_next;
    logic [15:0]   address_reg, address_next;
    logic [7:0]    event_reg, event_next;
    logic [7:0]    id_reg, id_next;
    logic          crc_enable_reg;

    // Result registers
    logic          m_valid_reg;
    status_t       status_reg;
    logic [CW-1:0] length_out_reg;
    logic [7:0]    command_out_reg;
    logic [15:0]   address_out_reg;
    logic [7:0]    event_out_reg;
    logic [7:0]    id_out_reg;
    logic          key_rpt_reg;
    logic [15:0]   rx_crc_reg;
    logic [15:0]   computed_crc_reg;

    logic          in_fire;
    logic          cfg_write;
    status_t       status_next;
    logic [15:0]   rx_crc_next;
    logic [15:0]   computed_crc_next;
    logic [LW-1:0] len_sum;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Update per-frame fields from the incoming byte
    always_comb begin
        header_good_next = header_good_reg;
        length_byte_next = length_byte_reg;
        command_next     = command_reg;
        address_next     = address_reg;
        event_next       = event_reg;
        id_next          = id_reg;
        case (byte_count_reg)
            CW'(0): begin
                if (s_rx_byte != HDR_BYTE0) header_good_next = 1'b0;
            end
            CW'(1): begin
                if (s_rx_byte != HDR_BYTE1) header_good_next = 1'b0;
            end
            CW'(2): length_byte_next = s_rx_byte;
            CW'(3): command_next = s_rx_byte;
            CW'(4): address_next = {s_rx_byte, address_reg[7:0]};
            CW'(5): address_next = {address_reg[15:8], s_rx_byte};
            CW'(6): event_next = s_rx_byte;
            CW'(8): id_next = s_rx_byte;
            default: ;
        endcase

        // Feed the byte that arrived two requests ago
        crc_next = (byte_count_reg >= CW'(5)) ? crc_feed(crc_reg, dly1_reg) : crc_reg;
        dly1_next = dly0_reg;
        dly0_next = s_rx_byte;

        byte_count_next = (byte_count_reg < CNT_SAT) ? byte_count_reg + CW'(1)
                                                     : byte_count_reg;
    end

    // Verdict, in order of precedence
    always_comb begin
        rx_crc_next       = {dly1_next, dly0_next};
        computed_crc_next = {crc_next[7:0], crc_next[15:8]};
        len_sum           = LW'(length_byte_next) + LW'(LEN_OFFSET);
        if (byte_count_next < CW'(MIN_FRAME)) begin
            status_next = ST_TOO_SHORT;
        end else if (!header_good_next) begin
            status_next = ST_BAD_HEADER;
        end else if (byte_count_next > CNT_MAX || len_sum != LW'(byte_count_next)) begin
            status_next = ST_LEN_MISM;
        end else if (crc_enable_reg && rx_crc_next != computed_crc_next) begin
            status_next = ST_CRC_MISM;
        end else begin
            status_next = ST_OK;
        end
    end

    // Advance frame state; clear it after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && s_frame_end)) begin
            byte_count_reg  <= '0;
            header_good_reg <= 1'b1;
            length_byte_reg <= '0;
            crc_reg         <= CRC_INIT;
            dly0_reg        <= '0;
            dly1_reg        <= '0;
            command_reg     <= '0;
            address_reg     <= '0;
            event_reg       <= '0;
            id_reg          <= '0;
        end else if (in_fire) begin
            byte_count_reg  <= byte_count_next;
            header_good_reg <= header_good_next;
            length_byte_reg <= length_byte_next;
            crc_reg         <= crc_next;
            dly0_reg        <= dly0_next;
            dly1_reg        <= dly1_next;
            command_reg     <= command_next;
            address_reg     <= address_next;
            event_reg       <= event_next;
            id_reg          <= id_next;
        end
    end

    // Hold the verdict until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire && s_frame_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && s_frame_end) begin
            status_reg       <= status_next;
            length_out_reg   <= byte_count_next;
            command_out_reg  <= command_next;
            address_out_reg  <= address_next;
            event_out_reg    <= event_next;
            id_out_reg       <= id_next;
            key_rpt_reg      <= (status_next == ST_OK) && (command_next == CMD_KEY_RPT);
            rx_crc_reg       <= rx_crc_next;
            computed_crc_reg <= computed_crc_next;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_enable_reg <= 1'b1;
        end else if (cfg_write && paddr[2] == REG_CRC_ENABLE) begin
            crc_enable_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_CRC_ENABLE) ? {31'd0, crc_enable_reg} : 32'd0;

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_frame_length  = length_out_reg;
    assign m_command       = command_out_reg;
    assign m_vp_address    = address_out_reg;
    assign m_key_action    = event_out_reg;
    assign m_key_id        = id_out_reg;
    assign m_is_key_report = key_rpt_reg;
    assign m_received_crc  = rx_crc_reg;
    assign m_computed_crc  = computed_crc_reg;

    // Checks
    `CRC16FC_ASSERT_NOW(a_count_sat, aclk, aresetn, 1'b1, byte_count_reg <= CNT_SAT, "byte count past saturation")
    `CRC16FC_ASSERT_NEXT(a_end_clears, aclk, aresetn, in_fire && s_frame_end, byte_count_reg == '0 && crc_reg == CRC_INIT && m_valid_reg, "frame end did not clear state or raise verdict")
    `CRC16FC_ASSERT_NEXT(a_no_spurious, aclk, aresetn, !m_valid_reg && !(in_fire && s_frame_end), !m_valid_reg, "verdict without frame end")
    `CRC16FC_ASSERT_NOW(a_ok_length, aclk, aresetn, m_valid_reg && status_reg == ST_OK, length_out_reg <= CNT_MAX && length_out_reg >= CW'(MIN_FRAME), "ok verdict with bad length")
    `CRC16FC_ASSERT_NOW(a_key_rpt, aclk, aresetn, m_valid_reg && key_rpt_reg, status_reg == ST_OK && command_out_reg == CMD_KEY_RPT, "key report flag inconsistent")

endmodule

/* tb/tb_crc16_frame_checker.sv */
// Self-checking testbench for the CRC-16 frame checker: bytes in, one verdict per frame out.
`timescale 1ns / 1ps

module tb_crc16_frame_checker;
    import crc16fc_pkg::*;

    localparam int          FRAME_CAP       = 64;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          HOLD_OFF_CYCLES = 200;
    localparam int          DRAIN_SLACK     = 4;
    localparam int          MAX_REPORTED    = 10;
    localparam logic [2:0]  ADDR_CRC_ENABLE = {REG_CRC_ENABLE, 2'b00};
    localparam logic [2:0]  ADDR_UNMAPPED   = 3'd4;

    typedef enum {FLAW_NONE, FLAW_HEADER, FLAW_LENGTH, FLAW_CRC} flaw_t;
    typedef enum {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_style_t;

    typedef struct packed {
        status_t     status;
        logic [6:0]  frame_len;
        logic [7:0]  command;
        logic [15:0] vp_address;
        logic [7:0]  key_action;
        logic [7:0]  key_id;
        logic        key_report;
        logic [15:0] rx_crc;
        logic [15:0] computed_crc;
    } verdict_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        s_frame_end;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [6:0]  m_frame_length;
    logic [7:0]  m_command;
    logic [15:0] m_vp_address;
    logic [7:0]  m_key_action;
    logic [7:0]  m_key_id;
    logic        m_is_key_report;
    logic [15:0] m_received_crc;
    logic [15:0] m_computed_crc;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Frame tracking state mirrored from the block
    logic [6:0]  seen_count;
    logic        header_ok;
    logic [7:0]  length_field;
    logic [15:0] running_crc;
    logic [7:0]  lag_byte0;
    logic [7:0]  lag_byte1;
    logic [7:0]  cmd_field;
    logic [15:0] addr_field;
    logic [7:0]  event_field;
    logic [7:0]  id_field;
    logic        crc_check_on;

    verdict_t     verdict_q[$];
    logic [7:0]   body_bytes[$];
    logic [7:0]   frame_bytes[$];
    int           mismatches;
    int           bytes_sent;
    int           cycle_count;
    int           burst_left;
    bit           sender_gaps;
    int           hold_off_req;
    ready_style_t rx_style;

    crc16_frame_checker #(
        .MAX_FRAME(FRAME_CAP)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .s_frame_end(s_frame_end),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_frame_length(m_frame_length),
        .m_command(m_command),
        .m_vp_address(m_vp_address),
        .m_key_action(m_key_action),
        .m_key_id(m_key_id),
        .m_is_key_report(m_is_key_report),
        .m_received_crc(m_received_crc),
        .m_computed_crc(m_computed_crc),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Reflected CRC-16 byte update, polynomial applied per shifted-out bit
    function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc_in,
                                                    input logic [7:0]  data);
        logic [15:0] r;
        r = crc_in ^ {8'h00, data};
        repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
        return r;
    endfunction

    function automatic void clear_frame_state();
        seen_count   = '0;
        header_ok    = 1'b1;
        length_field = '0;
        running_crc  = CRC_INIT;
        lag_byte0    = '0;
        lag_byte1    = '0;
        cmd_field    = '0;
        addr_field   = '0;
        event_field  = '0;
        id_field     = '0;
    endfunction

    // Fold one accepted byte into the frame state; queue a verdict on frame end
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        verdict_t v;
        int       idx;
        idx = int'(seen_count);
        case (idx)
            0: if (b != HDR_BYTE0) header_ok = 1'b0;
            1: if (b != HDR_BYTE1) header_ok = 1'b0;
            2: length_field = b;
            3: cmd_field = b;
            4: addr_field[15:8] = b;
            5: addr_field[7:0] = b;
            6: event_field = b;
            8: id_field = b;
            default: ;
        endcase
        if (idx >= 5) running_crc = modbus_crc_step(running_crc, lag_byte1);
        lag_byte1 = lag_byte0;
        lag_byte0 = b;
        if (int'(seen_count) < FRAME_CAP + 1) seen_count = seen_count + 7'd1;
        if (last) begin
            v.frame_len    = seen_count;
            v.command      = cmd_field;
            v.vp_address   = addr_field;
            v.key_action   = event_field;
            v.key_id       = id_field;
            v.rx_crc       = {lag_byte1, lag_byte0};
            v.computed_crc = {running_crc[7:0], running_crc[15:8]};
            if (int'(seen_count) < MIN_FRAME) begin
                v.status = ST_TOO_SHORT;
            end else if (!header_ok) begin
                v.status = ST_BAD_HEADER;
            end else if (int'(seen_count) > FRAME_CAP ||
                         int'(length_field) + LEN_OFFSET != int'(seen_count)) begin
                v.status = ST_LEN_MISM;
            end else if (crc_check_on && v.rx_crc != v.computed_crc) begin
                v.status = ST_CRC_MISM;
            end else begin
                v.status = ST_OK;
            end
            v.key_report = (v.status == ST_OK) && (cmd_field == CMD_KEY_RPT);
            verdict_q.push_back(v);
            clear_frame_state();
        end
    endfunction

    task automatic flag_mismatch(input string what, input verdict_t e, input verdict_t a);
        mismatches++;
        if (mismatches <= MAX_REPORTED) begin
            $display("%s at %0t", what, $realtime);
            $display("  expected st=%0d len=%0d cmd=%h addr=%h evt=%h id=%h key=%b rx=%h calc=%h",
                     e.status, e.frame_len, e.command, e.vp_address, e.key_action, e.key_id,
                     e.key_report, e.rx_crc, e.computed_crc);
            $display("  actual   st=%0d len=%0d cmd=%h addr=%h evt=%h id=%h key=%b rx=%h calc=%h",
                     a.status, a.frame_len, a.command, a.vp_address, a.key_action, a.key_id,
                     a.key_report, a.rx_crc, a.computed_crc);
        end
    endtask

    // Compare each accepted verdict with the oldest one predicted
    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            got.status       = status_t'(m_status);
            got.frame_len    = m_frame_length;
            got.command      = m_command;
            got.vp_address   = m_vp_address;
            got.key_action   = m_key_action;
            got.key_id       = m_key_id;
            got.key_report   = m_is_key_report;
            got.rx_crc       = m_received_crc;
            got.computed_crc = m_computed_crc;
            if (verdict_q.size() == 0) begin
                flag_mismatch("unexpected verdict", '0, got);
            end else begin
                want = verdict_q.pop_front();
                if (got !== want) flag_mismatch("verdict mismatch", want, got);
            end
        end
    end

    // Result sink: stall on the chosen style, honour long hold-off requests
    initial begin : result_sink
        int run_left;
        bit stall_phase;
        int hold_seen;
        m_ready     = 1'b0;
        run_left    = 0;
        stall_phase = 1'b0;
        hold_seen   = 0;
        forever begin
            @(negedge aclk);
            if (hold_seen != hold_off_req) begin
                hold_seen = hold_off_req;
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            case (rx_style)
                READY_ALWAYS: m_ready = 1'b1;
                READY_RANDOM: m_ready = ($urandom_range(0, 99) < 60);
                default: begin
                    if (run_left == 0) begin
                        stall_phase = !stall_phase;
                        run_left = stall_phase ? $urandom_range(1, 16) : $urandom_range(1, 8);
                    end
                    run_left--;
                    m_ready = !stall_phase;
                end
            endcase
        end
    end

    // Offer one byte request, hold it until taken; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (sender_gaps) begin
            if (burst_left == 0) begin
                s_valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        s_valid     = 1'b1;
        s_rx_byte   = b;
        s_frame_end = last;
        do @(posedge aclk); while (!s_ready);
        absorb_byte(b, last);
        bytes_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Wrap body_bytes in header, length and trailing CRC, then spoil it as asked
    task automatic frame_from_body(input flaw_t flaw);
        logic [15:0] crc;
        int          pos;
        crc = CRC_INIT;
        foreach (body_bytes[i]) crc = modbus_crc_step(crc, body_bytes[i]);
        frame_bytes.delete();
        frame_bytes.push_back(HDR_BYTE0);
        frame_bytes.push_back(HDR_BYTE1);
        frame_bytes.push_back(8'(body_bytes.size() + 2));
        foreach (body_bytes[i]) frame_bytes.push_back(body_bytes[i]);
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
        case (flaw)
            FLAW_HEADER: begin
                pos = $urandom_range(0, 1);
                frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
            end
            FLAW_LENGTH: frame_bytes[2] = frame_bytes[2] + 8'($urandom_range(1, 255));
            FLAW_CRC: begin
                pos = frame_bytes.size() - 1 - $urandom_range(0, 1);
                frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
            end
            default: ;
        endcase
    endtask

    // Random body of n bytes, command first
    task automatic random_body(input int n);
        body_bytes.delete();
        body_bytes.push_back(($urandom_range(0, 99) < 30) ? CMD_KEY_RPT : 8'($urandom));
        repeat (n - 1) body_bytes.push_back(8'($urandom));
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_CRC_ENABLE) crc_check_on = data[0];
        @(negedge aclk);
        // Read back the register at the same address
        if (prdata !== ((addr == ADDR_CRC_ENABLE) ? {31'd0, crc_check_on} : 32'd0)) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
                $display("register read at %0t: expected crc_enable=%b actual prdata=%h",
                         $realtime, crc_check_on, prdata);
            end
        end
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Wait for every predicted verdict, then let the pipeline settle
    task automatic wait_drained();
        while (verdict_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_SLACK) @(negedge aclk);
    endtask

    // Field extremes and the too-short, ok and bad-header verdicts in a few frames
    task automatic test_directed();
        rx_style    = READY_ALWAYS;
        sender_gaps = 1'b1;
        // single-byte runt
        frame_bytes.delete();
        frame_bytes.push_back(8'hFF);
        send_frame();
        // shortest frame that can pass
        body_bytes.delete();
        body_bytes.push_back(8'h00);
        frame_from_body(FLAW_NONE);
        send_frame();
        // key report with extreme field bytes
        body_bytes.delete();
        body_bytes.push_back(CMD_KEY_RPT);
        body_bytes.push_back(8'hFF);
        body_bytes.push_back(8'h00);
        body_bytes.push_back(8'h01);
        body_bytes.push_back(8'h00);
        body_bytes.push_back(8'hFF);
        frame_from_body(FLAW_NONE);
        send_frame();
        // broken header
        body_bytes.delete();
        body_bytes.push_back(8'h01);
        frame_from_body(FLAW_HEADER);
        send_frame();
    endtask

    // CRC and length failures, CRC check switched off, unmapped register write
    task automatic test_crc_control();
        random_body(3);
        frame_from_body(FLAW_CRC);
        send_frame();
        random_body(3);
        frame_from_body(FLAW_LENGTH);
        send_frame();
        wait_drained();
        // only bit 0 counts
        apb_write(ADDR_CRC_ENABLE, 32'hFFFF_FFFE);
        random_body(2);
        frame_from_body(FLAW_CRC);
        send_frame();
        wait_drained();
        apb_write(ADDR_UNMAPPED, 32'h0000_0001);
        random_body(4);
        frame_from_body(FLAW_CRC);
        send_frame();
        wait_drained();
        apb_write(ADDR_CRC_ENABLE, 32'h0000_0001);
    endtask

    // Size edges: full frame, one past, saturated count matching length byte, long bad header
    task automatic test_overflow();
        random_body(FRAME_CAP - 5);
        frame_from_body(FLAW_NONE);
        send_frame();
        random_body(FRAME_CAP - 4);
        frame_from_body(FLAW_NONE);
        send_frame();
        random_body(75);
        frame_from_body(FLAW_NONE);
        frame_bytes[2] = 8'(FRAME_CAP + 1 - LEN_OFFSET);
        send_frame();
        random_body(70);
        frame_from_body(FLAW_HEADER);
        send_frame();
    endtask

    // Hold the sink off while frames keep coming, so the input stalls
    task automatic test_backpressure();
        wait_drained();
        rx_style    = READY_ALWAYS;
        sender_gaps = 1'b0;
        hold_off_req++;
        repeat (8) begin
            random_body($urandom_range(1, 6));
            frame_from_body(FLAW_NONE);
            send_frame();
        end
    endtask

    // Mostly well-formed frames with random content, the rest broken or noise
    task automatic test_random_frames(input int n_bytes, input logic crc_on,
                                      input ready_style_t style, input bit gaps);
        int start;
        int pick;
        int n;
        flaw_t flaw;
        wait_drained();
        apb_write(ADDR_CRC_ENABLE, {31'd0, crc_on});
        rx_style    = style;
        sender_gaps = gaps;
        start       = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                // runt or line noise, sometimes with a good header
                n = (pick < 6) ? $urandom_range(1, MIN_FRAME - 1) : $urandom_range(1, 24);
                frame_bytes.delete();
                repeat (n) frame_bytes.push_back(8'($urandom));
                if (n >= 2 && $urandom_range(0, 1)) begin
                    frame_bytes[0] = HDR_BYTE0;
                    frame_bytes[1] = HDR_BYTE1;
                end
            end else begin
                n = $urandom_range(0, 99);
                if (n < 85) n = $urandom_range(1, 12);
                else if (n < 96) n = $urandom_range(13, FRAME_CAP - 3);
                else n = $urandom_range(FRAME_CAP - 2, 80);
                random_body(n);
                if (pick < 72) flaw = FLAW_NONE;
                else if (pick < 80) flaw = FLAW_HEADER;
                else if (pick < 88) flaw = FLAW_LENGTH;
                else flaw = FLAW_CRC;
                frame_from_body(flaw);
            end
            send_frame();
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_rx_byte    = '0;
        s_frame_end  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatches   = 0;
        bytes_sent   = 0;
        cycle_count  = 0;
        burst_left   = 0;
        sender_gaps  = 1'b1;
        hold_off_req = 0;
        rx_style     = READY_ALWAYS;
        crc_check_on = 1'b1;
        clear_frame_state();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_crc_control();
        test_overflow();
        test_backpressure();
        test_random_frames(250, 1'b1, READY_RANDOM, 1'b1);
        test_random_frames(250, 1'b0, READY_PATTERN, 1'b1);
        test_random_frames(250, 1'b1, READY_ALWAYS, 1'b0);
        test_random_frames(250, 1'b0, READY_RANDOM, 1'b0);
        test_random_frames(250, 1'b1, READY_PATTERN, 1'b1);

        wait_drained();
        repeat (10) @(posedge aclk);
        mismatches += verdict_q.size();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/crc16fc_pkg.sv
hdl/crc16_frame_checker.sv
tb/tb_crc16_frame_checker.sv
